@@ rtl/rv32im_execute_unit_defines.svh @@
// ----------------------------------------------------------------------------
// rv32im_execute_unit_defines
// Assertion macros shared by the execute unit.
// ----------------------------------------------------------------------------
`ifndef RV32IM_EXECUTE_UNIT_DEFINES_SVH
`define RV32IM_EXECUTE_UNIT_DEFINES_SVH

// assert that an implication holds on every clock edge outside reset
`define RVX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// assert that an implication holds in the next cycle
`define RVX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rvx_pkg.sv @@
// ----------------------------------------------------------------------------
// rvx_pkg
// Opcodes, state codes and small helpers for the RV32IM execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rvx_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned NREGS = 32;
  localparam int unsigned RIDX_W = 5;

  typedef enum logic [6:0] {
    OP_LOAD   = 7'h03,
    OP_FENCE  = 7'h0f,
    OP_IMM    = 7'h13,
    OP_AUIPC  = 7'h17,
    OP_STORE  = 7'h23,
    OP_REG    = 7'h33,
    OP_LUI    = 7'h37,
    OP_BRANCH = 7'h63,
    OP_JALR   = 7'h67,
    OP_JAL    = 7'h6f
  } opcode_e;

  typedef enum logic [1:0] {
    MREQ_NONE  = 2'd0,
    MREQ_READ  = 2'd1,
    MREQ_WRITE = 2'd2
  } mreq_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_OUT,
    ST_CLEAR
  } state_e;

  // divider control, top level to divider
  typedef struct packed {
    logic start;
    logic want_rem;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic lt_signed(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b);
    lt_signed = $signed(a) < $signed(b);
  endfunction

endpackage
`default_nettype wire

@@ rtl/rvx_divider.sv @@
// ----------------------------------------------------------------------------
// rvx_divider
// Radix-2 restoring divider for DIV and REM, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_divider (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rvx_pkg::div_ctrl_t       ctrl_i,
  input  wire logic [rvx_pkg::XLEN-1:0] a_i,
  input  wire logic [rvx_pkg::XLEN-1:0] b_i,
  output rvx_pkg::div_stat_t            stat_o,
  output logic      [rvx_pkg::XLEN-1:0] res_o
);
  import rvx_pkg::*;

  localparam int unsigned CNT_W = $clog2(XLEN + 1);

  logic [XLEN-1:0]  quo_q, quo_d, den_q, den_d;
  logic [XLEN:0]    rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             neg_q_q, neg_q_d, neg_r_q, neg_r_d, rem_sel_q, rem_sel_d;
  logic             spec_q, spec_d;
  logic [XLEN-1:0]  spec_val_q, spec_val_d;
  logic [XLEN:0]    trial;
  logic [XLEN:0]    shifted;

  always_comb begin
    quo_d = quo_q; den_d = den_q; rem_d = rem_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    neg_q_d = neg_q_q; neg_r_d = neg_r_q; rem_sel_d = rem_sel_q;
    spec_d = spec_q; spec_val_d = spec_val_q;
    shifted = {rem_q[XLEN-1:0], quo_q[XLEN-1]};
    trial = shifted - {1'b0, den_q};
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      rem_sel_d = ctrl_i.want_rem;
      neg_q_d = a_i[XLEN-1] ^ b_i[XLEN-1];
      neg_r_d = a_i[XLEN-1];
      quo_d = a_i[XLEN-1] ? (~a_i + 1'b1) : a_i;
      den_d = b_i[XLEN-1] ? (~b_i + 1'b1) : b_i;
      rem_d = '0;
      cnt_d = CNT_W'(XLEN);
      spec_d = 1'b0;
      spec_val_d = '0;
      if (b_i == '0) begin
        spec_d = 1'b1;
        spec_val_d = ctrl_i.want_rem ? a_i : '1;
      end else if (a_i == {1'b1, {(XLEN-1){1'b0}}} && b_i == '1) begin
        spec_d = 1'b1;
        spec_val_d = ctrl_i.want_rem ? '0 : a_i;
      end
    end else if (busy_q) begin
      if (spec_q || cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (!trial[XLEN]) begin
          rem_d = trial;
          quo_d = {quo_q[XLEN-2:0], 1'b1};
        end else begin
          rem_d = shifted;
          quo_d = {quo_q[XLEN-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; den_q <= den_d; rem_q <= rem_d;
    neg_q_q <= neg_q_d; neg_r_q <= neg_r_d; rem_sel_q <= rem_sel_d;
    spec_q <= spec_d; spec_val_q <= spec_val_d;
  end

  always_comb begin
    if (spec_q)          res_o = spec_val_q;
    else if (rem_sel_q)  res_o = neg_r_q ? (~rem_q[XLEN-1:0] + 1'b1) : rem_q[XLEN-1:0];
    else                 res_o = neg_q_q ? (~quo_q + 1'b1) : quo_q;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

@@ rtl/rv32im_execute_unit.sv @@
// ----------------------------------------------------------------------------
// rv32im_execute_unit
// Multi-cycle RV32IM integer execute stage with a RAM register file.
// ----------------------------------------------------------------------------
// One word is taken at a time. After reset a clearing pass zeroes all 32
// registers of the register file; no word is taken meanwhile. An ordinary
// instruction goes from acceptance through register read and execute/write
// back to the result; DIV and REM also pass through the bit-serial divider,
// which finishes early when the divisor is zero or on signed overflow. The
// register file is one synchronous RAM read at two addresses, written at one,
// so the register read step comes before execute. Results sit in an output
// register until taken; the next word is accepted once the result has gone.
`default_nettype none
`include "rv32im_execute_unit_defines.svh"
module rv32im_execute_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [6:0]  opcode_i,
  input  wire logic [2:0]  funct3_i,
  input  wire logic [6:0]  funct7_i,
  input  wire logic [4:0]  dest_reg_i,
  input  wire logic [4:0]  src1_reg_i,
  input  wire logic [4:0]  src2_reg_i,
  input  wire logic [31:0] immediate_i,
  input  wire logic [31:0] load_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      next_pc_o,
  output logic             branch_taken_o,
  output logic [1:0]       mem_request_o,
  output logic [31:0]      mem_address_o,
  output logic [31:0]      mem_write_data_o,
  output logic [1:0]       mem_size_o,
  output logic             illegal_o,
  output logic [31:0]      write_value_o
);
  import rvx_pkg::*;

  state_e state_q, state_d;

  // register file RAM, two read ports, one write port
  logic [XLEN-1:0] rf_mem [NREGS];
  logic [XLEN-1:0] rs1_q, rs2_q;
  logic            we;
  logic [RIDX_W-1:0] waddr;
  logic [XLEN-1:0] wdata;

  // latched word
  logic            mode_q;
  logic [6:0]      op_q, f7_q;
  logic [2:0]      f3_q;
  logic [4:0]      rd_q, ra_q, rb_q;
  logic [31:0]     imm_q, ld_q;

  logic [31:0]     pc_q, pc_d;
  logic [4:0]      pld_q, pld_d;
  logic [2:0]      pkind_q, pkind_d;
  logic [4:0]      clr_q;

  // result register
  logic [31:0]     r_npc_q, r_npc_d, r_addr_q, r_addr_d, r_wd_q, r_wd_d;
  logic [31:0]     r_wv_q, r_wv_d;
  logic            r_tk_q, r_tk_d, r_ill_q, r_ill_d;
  logic [1:0]      r_req_q, r_req_d, r_sz_q, r_sz_d;

  div_ctrl_t       dctl;
  div_stat_t       dst;
  logic [31:0]     dres;

  logic accept, deliver;
  assign accept  = in_valid_i && !in_stall_o;
  assign deliver = out_valid_o && !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  rvx_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dctl),
    .a_i    (rs1_q),
    .b_i    (rs2_q),
    .stat_o (dst),
    .res_o  (dres)
  );

  // execute decode
  logic        is_div;
  logic        wr_en;
  logic [31:0] wr_val, alu_b, alu_r, sum_ab;
  logic        alt, cond;

  always_comb begin
    alu_b = (op_q == OP_IMM) ? imm_q : rs2_q;
    alt   = (op_q == OP_IMM) ? (f3_q == 3'd5 && imm_q[31:5] != '0) : (f7_q != '0);
    unique case (f3_q)
      3'd0: alu_r = alt ? rs1_q - alu_b : rs1_q + alu_b;
      3'd1: alu_r = rs1_q << alu_b[4:0];
      3'd2: alu_r = {31'd0, lt_signed(rs1_q, alu_b)};
      3'd3: alu_r = {31'd0, rs1_q < alu_b};
      3'd4: alu_r = rs1_q ^ alu_b;
      3'd5: alu_r = alt ? 32'($signed(rs1_q) >>> alu_b[4:0]) : rs1_q >> alu_b[4:0];
      3'd6: alu_r = rs1_q | alu_b;
      default: alu_r = rs1_q & alu_b;
    endcase
  end

  assign sum_ab = rs1_q + imm_q;
  assign is_div = !mode_q && op_q == OP_REG && f7_q == 7'd1 &&
                  (f3_q == 3'd4 || f3_q == 3'd6);

  always_comb begin
    r_npc_d = pc_q + 32'd4; r_tk_d = 1'b0; r_req_d = MREQ_NONE; r_addr_d = '0;
    r_wd_d = '0; r_sz_d = '0; r_ill_d = 1'b0;
    wr_en = 1'b0; wr_val = '0; cond = 1'b0;
    pld_d = pld_q; pkind_d = pkind_q;
    if (mode_q) begin
      r_npc_d = pc_q;
      wr_en = 1'b1;
      case (pkind_q)
        3'd0: wr_val = {{24{ld_q[7]}}, ld_q[7:0]};
        3'd1: wr_val = {{16{ld_q[15]}}, ld_q[15:0]};
        3'd4: wr_val = {24'd0, ld_q[7:0]};
        3'd5: wr_val = {16'd0, ld_q[15:0]};
        default: wr_val = ld_q;
      endcase
    end else begin
      unique case (op_q)
        OP_REG: begin
          if (f7_q == 7'd1) begin
            if (f3_q == 3'd0) begin
              wr_en = 1'b1; wr_val = rs1_q * rs2_q;
            end else if (f3_q == 3'd7) begin
              r_ill_d = 1'b1;
            end
          end else begin
            wr_en = 1'b1; wr_val = alu_r;
          end
        end
        OP_IMM: begin
          wr_en = 1'b1; wr_val = alu_r;
        end
        OP_LOAD: begin
          if (f3_q == 3'd3 || f3_q == 3'd6 || f3_q == 3'd7) begin
            r_ill_d = 1'b1;
          end else begin
            r_req_d = MREQ_READ; r_addr_d = sum_ab; r_sz_d = f3_q[1:0];
            pld_d = rd_q; pkind_d = f3_q;
          end
        end
        OP_STORE: begin
          if (f3_q > 3'd2) begin
            r_ill_d = 1'b1;
          end else begin
            r_req_d = MREQ_WRITE; r_addr_d = sum_ab; r_wd_d = rs2_q;
            r_sz_d = f3_q[1:0];
          end
        end
        OP_JALR: begin
          if (f3_q != 3'd0) begin
            r_ill_d = 1'b1;
          end else begin
            r_npc_d = {sum_ab[31:1], 1'b0}; r_tk_d = 1'b1;
            wr_en = 1'b1; wr_val = pc_q + 32'd4;
          end
        end
        OP_BRANCH: begin
          case (f3_q)
            3'd0: cond = rs1_q == rs2_q;
            3'd1: cond = rs1_q != rs2_q;
            3'd4: cond = lt_signed(rs1_q, rs2_q);
            3'd5: cond = !lt_signed(rs1_q, rs2_q);
            3'd6: cond = rs1_q < rs2_q;
            3'd7: cond = rs1_q >= rs2_q;
            default: r_ill_d = 1'b1;
          endcase
          if (cond) begin
            r_npc_d = pc_q + imm_q; r_tk_d = 1'b1;
          end
        end
        OP_AUIPC: begin
          wr_en = 1'b1; wr_val = pc_q + imm_q;
        end
        OP_LUI: begin
          wr_en = 1'b1; wr_val = imm_q;
        end
        OP_JAL: begin
          r_npc_d = pc_q + imm_q; r_tk_d = 1'b1;
          wr_en = 1'b1; wr_val = pc_q + 32'd4;
        end
        OP_FENCE: ;
        default: r_ill_d = 1'b1;
      endcase
    end
    // divider result overrides at its finish
    if (state_q == ST_DIV) begin
      wr_en = 1'b1; wr_val = dres;
    end
    r_wv_d = (wr_en && (mode_q ? pld_q : rd_q) != '0) ? wr_val : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == 5'd31) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_READ;
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC:  state_d = is_div ? ST_DIV : ST_OUT;
      ST_DIV:   if (dst.done) state_d = ST_OUT;
      ST_OUT:   if (deliver) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    we = 1'b0; waddr = mode_q ? pld_q : rd_q; wdata = wr_val;
    dctl.start = 1'b0; dctl.want_rem = f3_q[1];
    pc_d = pc_q;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_q; wdata = '0;
      end
      ST_EXEC: begin
        dctl.start = is_div;
        we = wr_en && !is_div && waddr != '0;
        if (!mode_q) pc_d = r_npc_d;
      end
      ST_DIV: we = dst.done && waddr != '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) rf_mem[waddr] <= wdata;
    rs1_q <= rf_mem[ra_q];
    rs2_q <= rf_mem[rb_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pc_q    <= '0;
      pld_q   <= '0;
      pkind_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      pc_q <= pc_d;
      if (state_q == ST_EXEC) begin
        pld_q <= pld_d;
        pkind_q <= pkind_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i; op_q <= opcode_i; f3_q <= funct3_i; f7_q <= funct7_i;
      rd_q <= dest_reg_i; ra_q <= src1_reg_i; rb_q <= src2_reg_i;
      imm_q <= immediate_i; ld_q <= load_data_i;
    end
    if (state_q == ST_EXEC) begin
      r_npc_q <= r_npc_d; r_tk_q <= r_tk_d; r_req_q <= r_req_d;
      r_addr_q <= r_addr_d; r_wd_q <= r_wd_d; r_sz_q <= r_sz_d;
      r_ill_q <= r_ill_d; r_wv_q <= r_wv_d;
    end
    // PC has already advanced; only the quotient or remainder is new here
    if (state_q == ST_DIV && dst.done) r_wv_q <= r_wv_d;
  end

  assign next_pc_o        = r_npc_q;
  assign branch_taken_o   = r_tk_q;
  assign mem_request_o    = r_req_q;
  assign mem_address_o    = r_addr_q;
  assign mem_write_data_o = r_wd_q;
  assign mem_size_o       = r_sz_q;
  assign illegal_o        = r_ill_q;
  assign write_value_o    = r_wv_q;

  `RVX_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, accept, in_stall_o && !out_valid_o, "word accepted while busy")
  `RVX_ASSERT_IMP(a_div_only_in_div, clk_i, rst_ni, dst.done, state_q == ST_DIV, "divider finished outside divide state")
  `RVX_ASSERT_IMP(a_no_write_x0, clk_i, rst_ni, we && state_q != ST_CLEAR, waddr != '0, "write to x0")

endmodule
`default_nettype wire

@@ tb/sv/tb_rv32im_execute_unit.sv @@
// ----------------------------------------------------------------------------
// tb_rv32im_execute_unit
// Self-checking bench: directed and random instruction words are sent to the
// execute unit while a behavioural model in the bench predicts each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_rv32im_execute_unit;
  import rvx_pkg::*;

  // Packed result word, same field order as the ports
  typedef struct packed {
    logic [31:0] npc;
    logic        taken;
    logic [1:0]  req;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [1:0]  size;
    logic        ill;
    logic [31:0] wval;
  } exec_res_t;

  localparam int unsigned MAX_CYCLES = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [6:0]  opcode_i = '0;
  logic [2:0]  funct3_i = '0;
  logic [6:0]  funct7_i = '0;
  logic [4:0]  dest_reg_i = '0;
  logic [4:0]  src1_reg_i = '0;
  logic [4:0]  src2_reg_i = '0;
  logic [31:0] immediate_i = '0;
  logic [31:0] load_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] next_pc_o;
  logic        branch_taken_o;
  logic [1:0]  mem_request_o;
  logic [31:0] mem_address_o;
  logic [31:0] mem_write_data_o;
  logic [1:0]  mem_size_o;
  logic        illegal_o;
  logic [31:0] write_value_o;

  rv32im_execute_unit dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow architectural state
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [4:0]  ld_dest;
  logic [2:0]  ld_kind;

  exec_res_t   pending_results[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic logic [31:0] shift_ra(logic [31:0] a, logic [4:0] sh);
    shift_ra = $unsigned($signed(a) >>> sh);
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, logic rem);
    logic [31:0] ua, ub, q, r;
    if (b == 0) return rem ? a : 32'hffff_ffff;
    if (a == 32'h8000_0000 && b == 32'hffff_ffff) return rem ? 32'h0 : 32'h8000_0000;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    r = ua % ub;
    if (rem) return a[31] ? -r : r;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt,
                                         logic [31:0] a, logic [31:0] b);
    case (f3)
      3'd0: alu_op = alt ? a - b : a + b;
      3'd1: alu_op = a << b[4:0];
      3'd2: alu_op = {31'b0, lt_signed(a, b)};
      3'd3: alu_op = {31'b0, a < b};
      3'd4: alu_op = a ^ b;
      3'd5: alu_op = alt ? shift_ra(a, b[4:0]) : a >> b[4:0];
      3'd6: alu_op = a | b;
      default: alu_op = a & b;
    endcase
  endfunction

  // Advance shadow state by one word and return the expected result
  function automatic exec_res_t execute_word(logic md, logic [6:0] op, logic [2:0] f3,
      logic [6:0] f7, logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2,
      logic [31:0] imm, logic [31:0] ld);
    exec_res_t   e;
    logic [31:0] a, b, v;
    logic        do_wr, c;
    logic [4:0]  wr_idx;
    e = '0;
    a = arch_regs[rs1];
    b = arch_regs[rs2];
    e.npc = arch_pc + 4;
    do_wr = 1'b0;
    wr_idx = rd;
    v = '0;
    c = 1'b0;
    if (md) begin
      case (ld_kind)
        3'd0: v = {{24{ld[7]}}, ld[7:0]};
        3'd1: v = {{16{ld[15]}}, ld[15:0]};
        3'd4: v = {24'b0, ld[7:0]};
        3'd5: v = {16'b0, ld[15:0]};
        default: v = ld;
      endcase
      do_wr = 1'b1;
      wr_idx = ld_dest;
      e.npc = arch_pc;
    end else begin
      case (op)
        OP_REG: begin
          if (f7 == 7'd1) begin
            case (f3)
              3'd0: begin v = a * b; do_wr = 1'b1; end
              3'd4: begin v = sdiv(a, b, 1'b0); do_wr = 1'b1; end
              3'd6: begin v = sdiv(a, b, 1'b1); do_wr = 1'b1; end
              3'd7: e.ill = 1'b1;
              default: ;  // MULH variants and DIVU do nothing
            endcase
          end else begin
            v = alu_op(f3, f7 != 0, a, b);
            do_wr = 1'b1;
          end
        end
        OP_IMM: begin
          v = alu_op(f3, (f3 == 3'd5) && ((imm >> 5) != 0), a, imm);
          do_wr = 1'b1;
        end
        OP_LOAD: begin
          if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) e.ill = 1'b1;
          else begin
            e.req = MREQ_READ;
            e.addr = a + imm;
            e.size = f3[1:0];
            ld_dest = rd;
            ld_kind = f3;
          end
        end
        OP_STORE: begin
          if (f3 > 3'd2) e.ill = 1'b1;
          else begin
            e.req = MREQ_WRITE;
            e.addr = a + imm;
            e.wdata = b;
            e.size = f3[1:0];
          end
        end
        OP_JALR: begin
          if (f3 != 0) e.ill = 1'b1;
          else begin
            e.npc = (a + imm) & ~32'd1;
            e.taken = 1'b1;
            v = arch_pc + 4;
            do_wr = 1'b1;
          end
        end
        OP_BRANCH: begin
          case (f3)
            3'd0: c = a == b;
            3'd1: c = a != b;
            3'd4: c = lt_signed(a, b);
            3'd5: c = !lt_signed(a, b);
            3'd6: c = a < b;
            3'd7: c = a >= b;
            default: e.ill = 1'b1;
          endcase
          if (c) begin
            e.npc = arch_pc + imm;
            e.taken = 1'b1;
          end
        end
        OP_AUIPC: begin v = arch_pc + imm; do_wr = 1'b1; end
        OP_LUI: begin v = imm; do_wr = 1'b1; end
        OP_JAL: begin
          e.npc = arch_pc + imm;
          e.taken = 1'b1;
          v = arch_pc + 4;
          do_wr = 1'b1;
        end
        OP_FENCE: ;
        default: e.ill = 1'b1;
      endcase
      arch_pc = e.npc;
    end
    // x0 stays zero and reports no write
    if (do_wr && wr_idx != 0) begin
      arch_regs[wr_idx] = v;
      e.wval = v;
    end
    return e;
  endfunction

  // Send one word; prediction is made at acceptance
  task automatic send_word(logic md, logic [6:0] op, logic [2:0] f3, logic [6:0] f7,
      logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2, logic [31:0] imm,
      logic [31:0] ld);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    mode_i <= md; opcode_i <= op; funct3_i <= f3; funct7_i <= f7;
    dest_reg_i <= rd; src1_reg_i <= rs1; src2_reg_i <= rs2;
    immediate_i <= imm; load_data_i <= ld;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(execute_word(md, op, f3, f7, rd, rs1, rs2, imm, ld));
    words_sent++;
    @(negedge clk_i);
  endtask

  // Receiver stall, redrawn every falling edge
  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  // Result checker
  always @(posedge clk_i) begin
    exec_res_t got, want;
    cycle_count++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {next_pc_o, branch_taken_o, mem_request_o, mem_address_o,
             mem_write_data_o, mem_size_o, illegal_o, write_value_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: npc %h/%h tk %b/%b req %0d/%0d addr %h/%h wd %h/%h sz %0d/%0d ill %b/%b wv %h/%h",
                     results_seen, want.npc, got.npc, want.taken, got.taken,
                     want.req, got.req, want.addr, got.addr, want.wdata, got.wdata,
                     want.size, got.size, want.ill, got.ill, want.wval, got.wval);
        end
      end
    end
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[rv32im_execute_unit] ERROR");
      $finish;
    end
  end

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: rand_val = 32'h0;
      1: rand_val = 32'hffff_ffff;
      2: rand_val = 32'h8000_0000;
      3: rand_val = 32'h7fff_ffff;
      4: rand_val = $urandom_range(15);
      default: rand_val = $urandom;
    endcase
  endfunction

  // Extremes, each opcode and the listed corner cases
  task automatic test_directed();
    send_word(1, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ff80);     // return before any load
    send_word(0, OP_LUI, 0, 0, 1, 0, 0, 32'h8000_0000, 0);
    send_word(0, OP_IMM, 0, 0, 2, 0, 0, 32'hffff_ffff, 0);  // x2 = -1
    send_word(0, OP_LUI, 0, 0, 0, 0, 0, 32'h1234_5000, 0);  // x0 write dropped
    send_word(0, OP_REG, 4, 1, 3, 1, 2, 0, 0);              // DIV overflow
    send_word(0, OP_REG, 6, 1, 4, 1, 2, 0, 0);              // REM overflow
    send_word(0, OP_REG, 4, 1, 5, 1, 0, 0, 0);              // DIV by zero
    send_word(0, OP_REG, 6, 1, 6, 1, 0, 0, 0);              // REM by zero
    send_word(0, OP_REG, 7, 1, 7, 1, 2, 0, 0);              // REMU illegal
    send_word(0, OP_REG, 1, 1, 7, 1, 2, 0, 0);              // MULH no-op
    send_word(0, OP_REG, 5, 7'h7f, 8, 1, 2, 0, 0);          // SRA
    send_word(0, OP_IMM, 5, 0, 9, 1, 0, 32'h0000_0401, 0);  // SRAI
    send_word(0, OP_REG, 2, 0, 10, 1, 2, 0, 0);             // SLT signed
    send_word(0, OP_BRANCH, 6, 0, 0, 1, 2, 32'h10, 0);      // BLTU
    send_word(0, OP_BRANCH, 2, 0, 0, 1, 2, 32'h10, 0);      // illegal branch
    send_word(0, OP_JALR, 0, 0, 11, 2, 0, 32'h0, 0);        // bit 0 cleared
    send_word(0, OP_JAL, 0, 0, 12, 0, 0, 32'hffff_fffc, 0);
    send_word(0, OP_AUIPC, 0, 0, 13, 0, 0, 32'hffff_ffff, 0);
    send_word(0, OP_LOAD, 0, 0, 14, 2, 0, 32'h1, 0);
    send_word(1, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0080);       // LB sign extend
    send_word(1, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0017);       // repeated return
    send_word(0, OP_STORE, 2, 0, 0, 2, 1, 32'h7fff_ffff, 0);
    send_word(0, OP_STORE, 3, 0, 0, 2, 1, 0, 0);
    send_word(0, OP_FENCE, 0, 0, 0, 0, 0, 0, 0);
    send_word(0, 7'h73, 0, 0, 1, 0, 0, 0, 0);               // SYSTEM illegal
    drain();
  endtask

  // Mostly legal instructions with random fields, some noise
  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    logic [6:0] op;
    logic [6:0] f7;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(11))
        0: op = OP_REG;
        1: op = OP_IMM;
        2: op = OP_LOAD;
        3: op = OP_STORE;
        4: op = OP_BRANCH;
        5: op = OP_JALR;
        6: op = OP_JAL;
        7: op = OP_AUIPC;
        8: op = OP_LUI;
        9: op = OP_REG;
        10: op = OP_FENCE;
        default: op = 7'($urandom_range(127));
      endcase
      case ($urandom_range(3))
        0: f7 = 7'd0;
        1: f7 = 7'd1;
        2: f7 = 7'h20;
        default: f7 = 7'($urandom_range(127));
      endcase
      // a load is usually followed by its return word
      if (op == OP_LOAD && $urandom_range(3) != 0) begin
        send_word(1'b0, op, 3'($urandom_range(7)), f7, 5'($urandom_range(31)),
                  5'($urandom_range(31)), 5'($urandom_range(31)), rand_val(), $urandom);
        send_word(1'b1, 7'($urandom_range(127)), 3'($urandom_range(7)),
                  7'($urandom_range(127)), 5'($urandom_range(31)), 5'($urandom_range(31)),
                  5'($urandom_range(31)), $urandom, $urandom);
      end else
        send_word($urandom_range(19) == 0, op, 3'($urandom_range(7)), f7,
                  5'($urandom_range(31)), 5'($urandom_range(31)), 5'($urandom_range(31)),
                  rand_val(), $urandom);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc = '0;
    ld_dest = '0;
    ld_kind = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(250, 0, 0);
    test_random(250, 78, 0);
    test_random(250, 0, 78);
    test_random(250, 9, 9);
    repeat (50) @(negedge clk_i);
    $display("sent %0d words, checked %0d results across four idling phases",
             words_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[rv32im_execute_unit] OK");
    else
      $display("[rv32im_execute_unit] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
